// ===== rtl/cpp_pkg.sv =====
package cpp_pkg;

    // Geometry limits and register reset values
    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int HEIGHT_LIMIT      = 2048;
    localparam int MIN_DIM           = 3;

    localparam logic [11:0] WIDTH_RESET     = 12'd640;
    localparam logic [11:0] HEIGHT_RESET    = 12'd480;
    localparam logic [15:0] THRESHOLD_RESET = 16'd655;
    localparam logic [15:0] MAX_CORNERS_RESET = 16'd100;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH        = 2'd0,
        CFG_IMAGE_HEIGHT       = 2'd1,
        CFG_RESPONSE_THRESHOLD = 2'd2,
        CFG_MAX_CORNERS        = 2'd3
    } cfg_index_t;

    // Input pixel transfer
    typedef struct packed {
        logic [15:0] response_value;
        logic        start_of_frame;
    } pixel_t;

    // Output corner transfer
    typedef struct packed {
        logic [10:0] corner_x;
        logic [10:0] corner_y;
        logic [15:0] corner_response;
    } corner_t;

    // One column of the two stored rows
    typedef struct packed {
        logic [15:0] two_up;
        logic [15:0] one_up;
    } line_pair_t;

endpackage

// ===== rtl/cpp_line_buffer.sv =====
module cpp_line_buffer
    import cpp_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  line_pair_t                   wr_data,
    output line_pair_t                   rd_data
);

    // Both rows share one word per column: {two rows up, one row up}
    line_pair_t mem [MAX_WIDTH];
    line_pair_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a write to the same column at the same edge is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/corner_peak_picker_3x3_unit.sv =====
// 3x3 corner peak picker.
// Pixel channel: pixel_valid / pixel_stall / pixel_data carry one normalized
// response per transfer in raster order; start_of_frame marks pixel (0,0).
// Corner channel: corner_valid / corner_stall / corner_data carry one report
// (column, row, response) for each centre off the border that exceeds the
// threshold and is strictly greater than its eight neighbours, at most
// max_corners per frame, in raster order.
// Config channel: cfg_valid / cfg_ready write cfg_data to register cfg_index;
// cfg_ready is always high. Write only while the block is idle.
// Throughput: one pixel per clock while pixel_stall is low. The line store is a
// single-port-write, registered-read memory of MAX_WIDTH words; its registered
// read, the window compare and the output register form a three-stage pipeline,
// so a report leaves through stage 1, stage 2 and the output register after the
// pixel that completes its window (one row and one column after the centre pixel itself).
// Reset clears position, corner count, window and pipeline; registers return
// to 640x480, threshold 655, 100 corners. Line store contents are not cleared.
// A stall on the corner channel is absorbed by the output register; pixels
// that make no report keep flowing until a second report needs that register.
module corner_peak_picker_3x3_unit
    import cpp_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  pixel_t      pixel_data,
    output logic        corner_valid,
    input  logic        corner_stall,
    output corner_t     corner_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;

    // Configuration registers
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [15:0] threshold_reg;
    logic [15:0] max_corners_reg;

    // Position of the next pixel
    logic [CW-1:0] col_reg;
    logic [10:0]   row_reg;
    logic [15:0]   count_reg;

    // Stage 1: line store read in flight
    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    logic [15:0]   s1_value_reg;
    logic [10:0]   s1_row_reg;
    logic          s1_sof_reg;
    logic          s1_inwin_reg;
    logic          s1_fwrap_reg;

    // Stage 2: window compare
    logic          s2_valid_reg;
    logic [CW-1:0] s2_col_reg;
    logic [10:0]   s2_row_reg;
    logic          s2_sof_reg;
    logic          s2_inwin_reg;
    logic          s2_fwrap_reg;
    logic [15:0]   win_reg [9];

    // Output register
    logic    corner_valid_reg;
    corner_t corner_reg;

    logic          pix_go;
    logic          s1_go;
    logic          s2_go;
    logic          s2_report;
    logic          out_free;
    logic [WW-1:0] w_eff;
    logic [WW-1:0] w_cfg;
    logic [11:0]   h_eff;
    logic [CW-1:0] c0;
    logic [WW-1:0] c0x;
    logic [WW-1:0] c_inc;
    logic [10:0]   r0;
    logic [11:0]   r_inc;
    logic          in_win;
    logic          col_wrap;
    logic          frame_wrap;
    logic [CW-1:0] col_next;
    logic [10:0]   row_next;
    logic          peak;
    logic [15:0]   count_eff;
    logic [CW-1:0] x_m1;
    line_pair_t    lb_rd;
    line_pair_t    lb_wr;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= WIDTH_RESET;
            height_reg      <= HEIGHT_RESET;
            threshold_reg   <= THRESHOLD_RESET;
            max_corners_reg <= MAX_CORNERS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:        width_reg       <= cfg_data[11:0];
                CFG_IMAGE_HEIGHT:       height_reg      <= cfg_data[11:0];
                CFG_RESPONSE_THRESHOLD: threshold_reg   <= cfg_data;
                CFG_MAX_CORNERS:        max_corners_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped geometry
    assign w_cfg = WW'(width_reg);
    always_comb
    begin
        if (w_cfg < WW'(MIN_DIM))
            w_eff = WW'(MIN_DIM);
        else if (w_cfg > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = w_cfg;

        if (height_reg < 12'(MIN_DIM))
            h_eff = 12'(MIN_DIM);
        else if (height_reg > 12'(HEIGHT_LIMIT))
            h_eff = 12'(HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    // Handshake chain
    assign out_free    = !corner_valid_reg || !corner_stall;
    assign s2_go       = s2_valid_reg && (!s2_report || out_free);
    assign s1_go       = s1_valid_reg && (!s2_valid_reg || s2_go);
    assign pixel_stall = s1_valid_reg && !s1_go;
    assign pix_go      = pixel_valid && !pixel_stall;

    // Position of the accepted pixel and the advance
    always_comb
    begin
        c0         = pixel_data.start_of_frame ? '0 : col_reg;
        r0         = pixel_data.start_of_frame ? '0 : row_reg;
        c0x        = WW'(c0);
        in_win     = (c0x >= WW'(2)) && (r0 >= 11'd2) && (c0x < w_eff)
                     && ({1'b0, r0} < h_eff);
        c_inc      = c0x + WW'(1);
        r_inc      = {1'b0, r0} + 12'd1;
        col_wrap   = (c_inc >= w_eff);
        frame_wrap = col_wrap && (r_inc >= h_eff);
        col_next   = col_wrap ? '0 : c_inc[CW-1:0];
        if (!col_wrap)
            row_next = r0;
        else if (frame_wrap)
            row_next = '0;
        else
            row_next = r_inc[10:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_go)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_go)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_go)
        begin
            s1_col_reg   <= c0;
            s1_row_reg   <= r0;
            s1_value_reg <= pixel_data.response_value;
            s1_sof_reg   <= pixel_data.start_of_frame;
            s1_inwin_reg <= in_win;
            s1_fwrap_reg <= frame_wrap;
        end
    end

    // Line store: read at accept, write back as the pixel leaves stage 1
    assign lb_wr = '{two_up: lb_rd.one_up, one_up: s1_value_reg};

    cpp_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk     (clk),
        .rd_en   (pix_go),
        .rd_addr (c0),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    // Window shift and stage 2 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (s1_go)
            begin
                s2_valid_reg <= 1'b1;
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]     <= win_reg[k*3 + 1];
                    win_reg[k*3 + 1] <= win_reg[k*3 + 2];
                end
                win_reg[2] <= lb_rd.two_up;
                win_reg[5] <= lb_rd.one_up;
                win_reg[8] <= s1_value_reg;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_sof_reg   <= s1_sof_reg;
            s2_inwin_reg <= s1_inwin_reg;
            s2_fwrap_reg <= s1_fwrap_reg;
        end
    end

    // Peak test: centre above threshold and above all eight neighbours
    always_comb
    begin
        peak = (win_reg[4] > threshold_reg);
        for (int k = 0; k < 9; k++)
        begin
            if (k != 4 && win_reg[k] >= win_reg[4])
                peak = 1'b0;
        end
    end

    assign count_eff = s2_sof_reg ? '0 : count_reg;
    assign s2_report = s2_valid_reg && s2_inwin_reg && peak
                       && (count_eff < max_corners_reg);
    assign x_m1      = s2_col_reg - CW'(1);

    // Per-frame corner count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (s2_go)
        begin
            if (s2_fwrap_reg)
                count_reg <= '0;
            else if (s2_report)
                count_reg <= count_eff + 16'd1;
            else
                count_reg <= count_eff;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_valid_reg <= 1'b0;
        end
        else if (s2_go && s2_report)
        begin
            corner_valid_reg <= 1'b1;
        end
        else if (!corner_stall)
        begin
            corner_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_report)
        begin
            corner_reg.corner_x        <= 11'(x_m1);
            corner_reg.corner_y        <= s2_row_reg - 11'd1;
            corner_reg.corner_response <= win_reg[4];
        end
    end

    assign corner_valid = corner_valid_reg;
    assign corner_data  = corner_reg;

    // A report carries a response above the threshold in force when it was made
    a_report_above_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_go && s2_report |=> corner_valid_reg
            && corner_reg.corner_response > $past(threshold_reg))
        else $error("reported corner not above threshold");

    // Reported rows are never on the top border
    a_row_off_border: assert property (@(posedge clk) disable iff (!rst_n)
        corner_valid_reg |-> corner_reg.corner_y != 11'd0)
        else $error("reported corner on top border row");

    // A held compare stage keeps its item
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_go |=> s2_valid_reg && $stable(s2_col_reg)
            && $stable(s2_row_reg))
        else $error("compare stage lost a held item");

    // Each report within a frame advances the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        s2_go && s2_report && !s2_fwrap_reg |=> count_reg == $past(count_eff) + 16'd1)
        else $error("corner count did not advance");

endmodule

// ===== verif/corner_peak_picker_3x3_checker.sv =====
`timescale 1ns / 100ps

module corner_peak_picker_3x3_checker
    import cpp_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    input  logic        pixel_stall,
    input  pixel_t      pixel_data,
    input  logic        corner_valid,
    input  logic        corner_stall,
    input  corner_t     corner_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    // Shadow registers
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [15:0] thresh_reg;
    logic [15:0] max_corners_reg;

    // Shadow line store, window and raster position
    logic [15:0] row_above [MAX_WIDTH];
    logic [15:0] row_two_above [MAX_WIDTH];
    logic [15:0] win [9];
    int          col_pos;
    int          row_pos;
    int          corner_count;

    corner_t     expected_corners [$];
    corner_t     want;
    corner_t     rpt;
    int          fail_count;
    int          shown;

    initial
    begin
        for (int k = 0; k < MAX_WIDTH; k++)
        begin
            row_above[k] = '0;
            row_two_above[k] = '0;
        end
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Push one pixel through the predicted window; returns 1 when a corner is due
    function automatic bit scan_pixel(pixel_t px, output corner_t found);
        int          w;
        int          h;
        int          c;
        int          r;
        int          k;
        logic [15:0] top;
        logic [15:0] mid;
        logic [15:0] centre;
        bit          peak;

        w = clamp_dim(int'(width_reg), MAX_WIDTH);
        h = clamp_dim(int'(height_reg), HEIGHT_LIMIT);
        top = '0;
        mid = '0;
        found = '0;
        scan_pixel = 1'b0;

        if (px.start_of_frame)
        begin
            col_pos = 0;
            row_pos = 0;
            corner_count = 0;
        end
        c = col_pos;
        r = row_pos;

        // line store read and shift-in
        if (c < MAX_WIDTH)
        begin
            top = row_two_above[c];
            mid = row_above[c];
            row_two_above[c] = mid;
            row_above[c] = px.response_value;
        end

        // window shifts left, new column enters on the right
        for (k = 0; k < 3; k++)
        begin
            win[k * 3] = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px.response_value;

        // strict peak over threshold and all eight neighbors
        centre = win[4];
        peak = (centre > thresh_reg);
        for (k = 0; k < 9; k++)
        begin
            if (k != 4 && win[k] >= centre)
                peak = 1'b0;
        end

        if (c >= 2 && r >= 2 && c < w && r < h && peak &&
            corner_count < int'(max_corners_reg))
        begin
            found.corner_x = 11'(c - 1);
            found.corner_y = 11'(r - 1);
            found.corner_response = centre;
            corner_count++;
            scan_pixel = 1'b1;
        end

        // advance and wrap against the current geometry
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
                corner_count = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            thresh_reg = THRESHOLD_RESET;
            max_corners_reg = MAX_CORNERS_RESET;
            for (int k = 0; k < 9; k++)
                win[k] = '0;
            col_pos = 0;
            row_pos = 0;
            corner_count = 0;
            expected_corners.delete();
            fail_count = 0;
            shown = 0;
        end
        else
        begin
            // register write transfer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:        width_reg = cfg_data[11:0];
                    CFG_IMAGE_HEIGHT:       height_reg = cfg_data[11:0];
                    CFG_RESPONSE_THRESHOLD: thresh_reg = cfg_data;
                    CFG_MAX_CORNERS:        max_corners_reg = cfg_data;
                    default: ;
                endcase
            end

            // pixel transfer: predict, append to the tail of the queue
            if (pixel_valid && !pixel_stall)
            begin
                if (scan_pixel(pixel_data, rpt))
                    expected_corners = {expected_corners, rpt};
            end

            // corner transfer: compare with oldest prediction
            if (corner_valid && !corner_stall)
            begin
                if (expected_corners.size() == 0)
                begin
                    fail_count++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("unexpected corner: x=%0d y=%0d resp=%0d",
                                 corner_data.corner_x, corner_data.corner_y,
                                 corner_data.corner_response);
                    end
                end
                else
                begin
                    want = expected_corners.pop_front();
                    if (want.corner_x !== corner_data.corner_x ||
                        want.corner_y !== corner_data.corner_y ||
                        want.corner_response !== corner_data.corner_response)
                    begin
                        fail_count++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display("corner mismatch: exp %0d,%0d,%0d got %0d,%0d,%0d",
                                     want.corner_x, want.corner_y, want.corner_response,
                                     corner_data.corner_x, corner_data.corner_y,
                                     corner_data.corner_response);
                        end
                    end
                end
            end
        end
        mismatches <= fail_count;
        outstanding <= expected_corners.size();
    end

endmodule

// ===== verif/corner_peak_picker_3x3_unit_tb.sv =====
`timescale 1ns / 100ps

module corner_peak_picker_3x3_unit_tb;
    import cpp_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 750;

    typedef enum int {
        STYLE_FULL,
        STYLE_TIES,
        STYLE_SPARSE
    } content_style_t;

    logic        clk;
    logic        rst_n;
    logic        pixel_valid;
    logic        pixel_stall;
    pixel_t      pixel_data;
    logic        corner_valid;
    logic        corner_stall;
    corner_t     corner_data;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [15:0] cfg_data;

    int          mismatches;
    int          outstanding;
    bit          hold_go;
    bit          hold_on;
    bit          tx_calm;
    bit          rx_calm;

    corner_peak_picker_3x3_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_data   (pixel_data),
        .corner_valid (corner_valid),
        .corner_stall (corner_stall),
        .corner_data  (corner_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    corner_peak_picker_3x3_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_data   (pixel_data),
        .corner_valid (corner_valid),
        .corner_stall (corner_stall),
        .corner_data  (corner_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Corner receiver: random stall bursts, plus the long hold-off
    initial
    begin
        int burst;
        int roll;
        burst = 0;
        corner_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst == 0 && !rx_calm)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    burst = 0;
                else if (roll < 95)
                    burst = $urandom_range(1, 3);
                else
                    burst = $urandom_range(10, 50);
            end
            corner_stall <= hold_on || (burst > 0);
            if (burst > 0)
                burst--;
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // Watchdog: cycles with no transfer on any channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (corner_valid && !corner_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        if (tx_calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] make_response(content_style_t style);
        case (style)
            STYLE_TIES:
                // few levels so neighbors often tie with the centre
                return 16'($urandom_range(0, 3)) * 16'h5555;
            STYLE_SPARSE:
                if ($urandom_range(0, 99) < 15)
                    return 16'($urandom_range(32768, 65535));
                else
                    return 16'($urandom_range(0, 2000));
            default:
                return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One pixel transfer, after a random gap
    task automatic send_pixel(logic [15:0] value, bit sof);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_data.response_value <= value;
        pixel_data.start_of_frame <= sof;
        @(posedge clk);
        while (pixel_stall) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_regs(int w, int h, int thr, int maxc);
        write_reg(CFG_IMAGE_WIDTH, 16'(w));
        write_reg(CFG_IMAGE_HEIGHT, 16'(h));
        write_reg(CFG_RESPONSE_THRESHOLD, 16'(thr));
        write_reg(CFG_MAX_CORNERS, 16'(maxc));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, let every expected corner arrive and the pipeline drain
    task automatic settle();
        @(negedge clk);
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int w, int h, int thr, int maxc, content_style_t style,
                             int pixels, bit first_sof, bit noisy);
        int  i;
        bit  sof;
        program_regs(w, h, thr, maxc);
        for (i = 0; i < pixels; i++)
        begin
            sof = (i == 0) ? first_sof : (noisy && $urandom_range(0, 99) < 2);
            send_pixel(make_response(style), sof);
        end
        settle();
    endtask

    // Stimulus
    initial
    begin
        int             w;
        int             h;
        int             thr;
        int             maxc;
        int             cw;
        int             ch;
        int             pixels;
        int             pixels_sent;
        int             phase;
        int             roll;
        int             k;
        content_style_t style;

        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        hold_go = 1'b0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // width below minimum clamps to 3; full-scale centre just above threshold
        // and just above each neighbor
        program_regs(0, 3, 65534, 1);
        for (k = 0; k < 9; k++)
            send_pixel((k == 4) ? 16'hFFFF : 16'hFFFE, k == 0);
        settle();

        // no frame mark: previous frame wrapped and cleared the count;
        // second peak is dropped at the count limit of one
        program_regs(5, 3, 0, 1);
        for (k = 0; k < 15; k++)
            send_pixel((k == 6) ? 16'd10 : ((k == 8) ? 16'd20 : 16'd0), 1'b0);
        settle();

        // geometry shrinks mid-frame: position falls outside, then wraps
        run_phase(8, 6, 1000, 65535, STYLE_SPARSE, 29, 1'b1, 1'b0);
        run_phase(4, 3, 1000, 65535, STYLE_SPARSE, 30, 1'b0, 1'b0);

        // oversize geometry clamps to the limits; the top rows give no corners
        tx_calm = 1'b1;
        run_phase(4095, 4095, 32768, 65535, STYLE_SPARSE, 40, 1'b1, 1'b0);
        tx_calm = 1'b0;

        // random phases of small frames
        pixels_sent = 0;
        phase = 0;
        while (pixels_sent < RANDOM_PIXELS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                w = $urandom_range(0, 2);
            else if (roll < 20)
                w = 3;
            else
                w = $urandom_range(3, 12);
            h = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 2) : $urandom_range(3, 6);

            roll = $urandom_range(0, 99);
            if (roll < 15)
                thr = 0;
            else if (roll < 25)
                thr = 65535;
            else if (roll < 60)
                thr = $urandom_range(0, 65535);
            else
                thr = $urandom_range(0, 4000);

            roll = $urandom_range(0, 99);
            if (roll < 10)
                maxc = 0;
            else if (roll < 25)
                maxc = $urandom_range(1, 3);
            else if (roll < 35)
                maxc = 65535;
            else if (roll < 50)
                maxc = $urandom_range(0, 65535);
            else
                maxc = $urandom_range(4, 50);

            style = content_style_t'($urandom_range(0, 2));
            cw = (w < MIN_DIM) ? MIN_DIM : w;
            ch = (h < MIN_DIM) ? MIN_DIM : h;
            pixels = cw * ch * $urandom_range(1, 3) + $urandom_range(0, cw * ch - 1);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);

            // one dense phase under a long receiver hold-off
            if (phase == 2)
            begin
                w = 10;
                h = 6;
                thr = 0;
                maxc = 65535;
                style = STYLE_SPARSE;
                pixels = 180;
                tx_calm = 1'b1;
                rx_calm = 1'b1;
                hold_go = 1'b1;
            end

            run_phase(w, h, thr, maxc, style, pixels, 1'b1, 1'b1);
            pixels_sent += pixels;
            phase++;
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
